// ----- sv/quaternion_product_and_rotate_macros.svh -----
// assertion macros for the quaternion product and rotate block
`ifndef QUATERNION_PRODUCT_AND_ROTATE_MACROS_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_MACROS_SVH
`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define QPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qpr assertion failed");
// condition that must never be seen outside reset
`define QPR_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("qpr forbidden condition seen");
`else
`define QPR_ASSERT(lbl, prop)
`define QPR_NEVER(lbl, cond)
`endif
`endif

// ----- sv/qpr_pkg.sv -----
// shared types and constants for the quaternion product and rotate block
`timescale 1ns / 1ps
package qpr_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int SUM_W      = PROD_W + 2;
  localparam int SHR_W      = SUM_W - FRAC_BITS;
  localparam int NCOMP      = 4;
  localparam int NTERM      = 4;

  // component order w, x, y, z
  localparam int C_W = 0;
  localparam int C_X = 1;
  localparam int C_Y = 2;
  localparam int C_Z = 3;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [SHR_W-1:0]      shr_t;

  localparam word_t WORD_MAX   = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t FIX_ONE    = word_t'(64'sd1 << FRAC_BITS);
  localparam sum_t  ROUND_HALF = sum_t'(1) << (FRAC_BITS - 1);

  // subtract masks, [component][term]
  localparam logic [NCOMP-1:0][NTERM-1:0] HAM_NEG =
    {4'b0010, 4'b0010, 4'b0010, 4'b1110};
  localparam logic [NCOMP-1:0][NTERM-1:0] ROT_NEG =
    {4'b1010, 4'b1010, 4'b1010, 4'b0000};

  // information that rides along with a word through a product unit
  typedef struct packed {
    logic                   mode;
    word_t [NCOMP-1:0]      a;
    logic                   ovf;
  } side_t;

  // operand pairs for four 4-term sums of products
  typedef struct packed {
    word_t [NCOMP-1:0][NTERM-1:0] x;
    word_t [NCOMP-1:0][NTERM-1:0] y;
    logic  [NCOMP-1:0][NTERM-1:0] neg;
    side_t                        side;
  } qmul_in_t;

  typedef struct packed {
    word_t [NCOMP-1:0] r;
    logic  [NCOMP-1:0] sat;
    side_t             side;
  } qmul_out_t;

endpackage

// ----- sv/qpr_if.sv -----
// handshake channels for operand and result words
`timescale 1ns / 1ps
interface qpr_op_if;
  logic          valid;
  logic          ready;
  logic          mode;
  qpr_pkg::word_t a_w;
  qpr_pkg::word_t a_x;
  qpr_pkg::word_t a_y;
  qpr_pkg::word_t a_z;
  qpr_pkg::word_t b_w;
  qpr_pkg::word_t b_x;
  qpr_pkg::word_t b_y;
  qpr_pkg::word_t b_z;
  modport source(output valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                 input ready);
  modport sink(input valid, mode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
               output ready);
endinterface

interface qpr_res_if;
  logic          valid;
  logic          ready;
  qpr_pkg::word_t r_w;
  qpr_pkg::word_t r_x;
  qpr_pkg::word_t r_y;
  qpr_pkg::word_t r_z;
  logic          overflow;
  modport source(output valid, r_w, r_x, r_y, r_z, overflow, input ready);
  modport sink(input valid, r_w, r_x, r_y, r_z, overflow, output ready);
endinterface

// ----- sv/qpr_qmul.sv -----
// three-stage unit: sixteen products, four signed sums, round and saturate
`timescale 1ns / 1ps
`include "quaternion_product_and_rotate_macros.svh"
module qpr_qmul (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  qpr_pkg::qmul_in_t  in_op,
  output logic               out_valid,
  input  logic               out_ready,
  output qpr_pkg::qmul_out_t out_res
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  qpr_pkg::prod_t p1 [qpr_pkg::NCOMP][qpr_pkg::NTERM];
  logic [qpr_pkg::NCOMP-1:0][qpr_pkg::NTERM-1:0] neg1;
  qpr_pkg::side_t side1, side2, side3;

  qpr_pkg::sum_t s2_next [qpr_pkg::NCOMP];
  qpr_pkg::sum_t s2 [qpr_pkg::NCOMP];

  qpr_pkg::word_t [qpr_pkg::NCOMP-1:0] r3_next, r3;
  logic [qpr_pkg::NCOMP-1:0] sat3_next, sat3;
  logic sat_ok;

  // stage enables, bubbles collapse
  always_comb begin
    en3 = !v3 || out_ready;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign in_ready = en1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int c = 0; c < qpr_pkg::NCOMP; c++) begin
        for (int t = 0; t < qpr_pkg::NTERM; t++) begin
          p1[c][t] <= qpr_pkg::prod_t'($signed(in_op.x[c][t]))
                    * qpr_pkg::prod_t'($signed(in_op.y[c][t]));
        end
      end
      neg1  <= in_op.neg;
      side1 <= in_op.side;
    end
  end

  // stage 2: signed four-term sums
  always_comb begin
    for (int c = 0; c < qpr_pkg::NCOMP; c++) begin
      s2_next[c] = '0;
      for (int t = 0; t < qpr_pkg::NTERM; t++) begin
        if (neg1[c][t]) begin
          s2_next[c] = s2_next[c] - qpr_pkg::sum_t'(p1[c][t]);
        end else begin
          s2_next[c] = s2_next[c] + qpr_pkg::sum_t'(p1[c][t]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2    <= s2_next;
      side2 <= side1;
    end
  end

  // stage 3: round half up, drop fraction, clamp to word range
  always_comb begin
    qpr_pkg::sum_t rnd;
    qpr_pkg::shr_t shr;
    for (int c = 0; c < qpr_pkg::NCOMP; c++) begin
      rnd = s2[c] + qpr_pkg::ROUND_HALF;
      shr = qpr_pkg::shr_t'(rnd[qpr_pkg::SUM_W-1:qpr_pkg::FRAC_BITS]);
      if (shr > qpr_pkg::shr_t'(qpr_pkg::WORD_MAX)) begin
        r3_next[c]   = qpr_pkg::WORD_MAX;
        sat3_next[c] = 1'b1;
      end else if (shr < qpr_pkg::shr_t'(qpr_pkg::WORD_MIN)) begin
        r3_next[c]   = qpr_pkg::WORD_MIN;
        sat3_next[c] = 1'b1;
      end else begin
        r3_next[c]   = shr[qpr_pkg::WORD_WIDTH-1:0];
        sat3_next[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      r3    <= r3_next;
      sat3  <= sat3_next;
      side3 <= side2;
    end
  end

  assign out_valid    = v3;
  assign out_res.r    = r3;
  assign out_res.sat  = sat3;
  assign out_res.side = side3;

  // every clamped component sits on a bound
  always_comb begin
    sat_ok = 1'b1;
    for (int c = 0; c < qpr_pkg::NCOMP; c++) begin
      if (sat3[c] && r3[c] != qpr_pkg::WORD_MAX && r3[c] != qpr_pkg::WORD_MIN) begin
        sat_ok = 1'b0;
      end
    end
  end

  `QPR_ASSERT(a_blocked_only_when_full, !in_ready |-> (v1 && v2 && v3 && !out_ready))
  `QPR_ASSERT(a_held_stage_keeps_word, (v2 && !en2) |=> v2)
  `QPR_ASSERT(a_clamp_on_bound, out_valid |-> sat_ok)

endmodule

// ----- sv/quaternion_product_and_rotate.sv -----
// top level: Hamilton product or vector rotation in two pipelined passes
//
//   channel  role    carries
//   op       sink    mode, a_w..a_z, b_w..b_z
//   res      source  r_w..r_z, overflow
//
// One word per cycle sustained when res is not held. Two three-stage
// product units run in series (multiply, four-term sum, round and
// clamp); the second pass rotates by conj(a) or passes the product
// through by a multiply by one.
// rst clears the valid bits only. A held result stalls only the stages
// behind it; empty stages keep taking words.
`timescale 1ns / 1ps
`include "quaternion_product_and_rotate_macros.svh"
module quaternion_product_and_rotate (
  input  logic clk,
  input  logic rst,
  qpr_op_if.sink    op,
  qpr_res_if.source res
);

  qpr_pkg::word_t [qpr_pkg::NCOMP-1:0] a, b, t, a2;

  qpr_pkg::qmul_in_t  u1_in, u2_in;
  qpr_pkg::qmul_out_t u1_out, u2_out;
  logic u1_out_valid, u2_in_ready, u2_out_valid;

  // first pass operands, scalar of b dropped in rotate mode
  always_comb begin
    a[qpr_pkg::C_W] = op.a_w;
    a[qpr_pkg::C_X] = op.a_x;
    a[qpr_pkg::C_Y] = op.a_y;
    a[qpr_pkg::C_Z] = op.a_z;
    b[qpr_pkg::C_W] = op.mode ? '0 : op.b_w;
    b[qpr_pkg::C_X] = op.b_x;
    b[qpr_pkg::C_Y] = op.b_y;
    b[qpr_pkg::C_Z] = op.b_z;

    u1_in.x[0] = {a[3], a[2], a[1], a[0]};
    u1_in.y[0] = {b[3], b[2], b[1], b[0]};
    u1_in.x[1] = {a[0], b[0], a[3], a[2]};
    u1_in.y[1] = {b[1], a[1], b[2], b[3]};
    u1_in.x[2] = {a[0], b[0], a[1], a[3]};
    u1_in.y[2] = {b[2], a[2], b[3], b[1]};
    u1_in.x[3] = {a[0], b[0], a[2], a[1]};
    u1_in.y[3] = {b[3], a[3], b[1], b[2]};
    u1_in.neg  = qpr_pkg::HAM_NEG;

    u1_in.side.mode = op.mode;
    u1_in.side.a    = a;
    u1_in.side.ovf  = 1'b0;
  end

  qpr_qmul u_pass1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (op.valid),
    .in_ready  (op.ready),
    .in_op     (u1_in),
    .out_valid (u1_out_valid),
    .out_ready (u2_in_ready),
    .out_res   (u1_out)
  );

  // second pass: t * conj(a) for rotate, t * 1.0 for product
  always_comb begin
    t  = u1_out.r;
    a2 = u1_out.side.a;
    u2_in.x = '0;
    u2_in.y = '0;
    if (u1_out.side.mode) begin
      u2_in.x[1] = {t[0], a2[0], t[2], t[3]};
      u2_in.y[1] = {a2[1], t[1], a2[3], a2[2]};
      u2_in.x[2] = {t[0], a2[0], t[3], t[1]};
      u2_in.y[2] = {a2[2], t[2], a2[1], a2[3]};
      u2_in.x[3] = {t[0], a2[0], t[1], t[2]};
      u2_in.y[3] = {a2[3], t[3], a2[2], a2[1]};
      u2_in.neg  = qpr_pkg::ROT_NEG;
    end else begin
      for (int c = 0; c < qpr_pkg::NCOMP; c++) begin
        u2_in.x[c][0] = t[c];
        u2_in.y[c][0] = qpr_pkg::FIX_ONE;
      end
      u2_in.neg = '0;
    end
    u2_in.side.mode = u1_out.side.mode;
    u2_in.side.a    = a2;
    u2_in.side.ovf  = |u1_out.sat;
  end

  qpr_qmul u_pass2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (u1_out_valid),
    .in_ready  (u2_in_ready),
    .in_op     (u2_in),
    .out_valid (u2_out_valid),
    .out_ready (res.ready),
    .out_res   (u2_out)
  );

  // result word
  assign res.valid    = u2_out_valid;
  assign res.r_w      = u2_out.r[qpr_pkg::C_W];
  assign res.r_x      = u2_out.r[qpr_pkg::C_X];
  assign res.r_y      = u2_out.r[qpr_pkg::C_Y];
  assign res.r_z      = u2_out.r[qpr_pkg::C_Z];
  assign res.overflow = u2_out.side.ovf | (|u2_out.sat);

  `QPR_ASSERT(a_rotate_scalar_zero, (u2_out_valid && u2_out.side.mode) |-> (u2_out.r[qpr_pkg::C_W] == '0))
  `QPR_NEVER(a_product_pass_exact, u2_out_valid && !u2_out.side.mode && (u2_out.sat != '0))

endmodule

// ----- tb/tb_top.sv -----
// self-checking bench for the quaternion product and rotate block
`timescale 1ns / 1ps
module tb_top;
  import qpr_pkg::*;

  localparam logic MODE_PRODUCT = 1'b0;
  localparam logic MODE_ROTATE  = 1'b1;
  localparam int   DRAIN_CYCLES = 12;
  localparam int   LONG_HOLD    = 120;

  typedef struct {
    logic  mode;
    word_t a_w, a_x, a_y, a_z;
    word_t b_w, b_x, b_y, b_z;
  } quat_op_t;

  typedef struct {
    word_t r_w, r_x, r_y, r_z;
    logic  overflow;
  } quat_res_t;

  typedef longint quad_t [4];

  // golden quaternion arithmetic plus the queue of results still owed
  class quat_scoreboard;
    quat_res_t awaited[$];
    int unsigned n_products, n_rotations, n_saturated, n_checked, n_errors;

    function logic signed [127:0] wide_mul(longint x, longint y);
      logic signed [127:0] wx, wy;
      wx = x;
      wy = y;
      return wx * wy;
    endfunction

    // round half up to the word grid, clamp to the word range
    function longint round_clamp(logic signed [127:0] acc, output bit sat);
      logic signed [127:0] sh, hi_lim, lo_lim;
      hi_lim = WORD_MAX;
      lo_lim = WORD_MIN;
      sh = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      sat = 1'b0;
      if (sh > hi_lim) begin
        sh = hi_lim;
        sat = 1'b1;
      end else if (sh < lo_lim) begin
        sh = lo_lim;
        sat = 1'b1;
      end
      return longint'(sh);
    endfunction

    function longint sum4(longint p, longint q, longint r, longint s,
                          longint t, longint u, longint v, longint w,
                          output bit sat);
      return round_clamp(wide_mul(p, q) + wide_mul(r, s) + wide_mul(t, u)
                         + wide_mul(v, w), sat);
    endfunction

    // Hamilton product, each component rounded and clamped on its own
    function void hamilton(input quad_t a, input quad_t b, output quad_t r,
                           output bit [3:0] sat);
      bit s0, s1, s2, s3;
      r[C_W] = sum4(a[C_W], b[C_W], a[C_X], -b[C_X], a[C_Y], -b[C_Y],
                    a[C_Z], -b[C_Z], s0);
      r[C_X] = sum4(a[C_Y], b[C_Z], a[C_Z], -b[C_Y], b[C_W], a[C_X],
                    a[C_W], b[C_X], s1);
      r[C_Y] = sum4(a[C_Z], b[C_X], a[C_X], -b[C_Z], b[C_W], a[C_Y],
                    a[C_W], b[C_Y], s2);
      r[C_Z] = sum4(a[C_X], b[C_Y], a[C_Y], -b[C_X], b[C_W], a[C_Z],
                    a[C_W], b[C_Z], s3);
      sat = {s3, s2, s1, s0};
    endfunction

    function quat_res_t quat_result(quat_op_t op);
      quad_t qa, qb, t, c, r;
      bit [3:0] m1, m2;
      quat_res_t e;
      qa = '{op.a_w, op.a_x, op.a_y, op.a_z};
      qb = '{op.b_w, op.b_x, op.b_y, op.b_z};
      if (op.mode == MODE_PRODUCT) begin
        hamilton(qa, qb, r, m1);
        e.overflow = |m1;
      end else begin
        // a * (0, v) * conj(a); the scalar of the second pass is dropped
        qb[C_W] = 0;
        hamilton(qa, qb, t, m1);
        c = '{qa[C_W], -qa[C_X], -qa[C_Y], -qa[C_Z]};
        hamilton(t, c, r, m2);
        e.overflow = (|m1) || (|m2[3:1]);
        r[C_W] = 0;
      end
      e.r_w = word_t'(r[C_W]);
      e.r_x = word_t'(r[C_X]);
      e.r_y = word_t'(r[C_Y]);
      e.r_z = word_t'(r[C_Z]);
      return e;
    endfunction

    function void note_operands(quat_op_t op);
      quat_res_t e;
      e = quat_result(op);
      if (op.mode == MODE_PRODUCT) n_products++;
      else n_rotations++;
      if (e.overflow) n_saturated++;
      awaited.push_back(e);
    endfunction

    function void check_result(quat_res_t got);
      quat_res_t e;
      if (awaited.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result word: w=%h x=%h y=%h z=%h ovf=%b",
                   got.r_w, got.r_x, got.r_y, got.r_z, got.overflow);
        return;
      end
      e = awaited.pop_front();
      n_checked++;
      if (got.r_w !== e.r_w || got.r_x !== e.r_x || got.r_y !== e.r_y ||
          got.r_z !== e.r_z || got.overflow !== e.overflow) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch on result %0d: exp w=%h x=%h y=%h z=%h ovf=%b, got w=%h x=%h y=%h z=%h ovf=%b",
                   n_checked, e.r_w, e.r_x, e.r_y, e.r_z, e.overflow,
                   got.r_w, got.r_x, got.r_y, got.r_z, got.overflow);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   hold_request = 1'b0;
  int unsigned held_cycles = 0;
  int unsigned stalled_in = 0;

  qpr_op_if  op_ch();
  qpr_res_if res_ch();

  quat_scoreboard sb = new();

  quaternion_product_and_rotate dut (
    .clk (clk),
    .rst (rst),
    .op  (op_ch),
    .res (res_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // watch accepted operand words
  always @(posedge clk) begin
    if (!rst && op_ch.valid && op_ch.ready)
      sb.note_operands(quat_op_t'{op_ch.mode, op_ch.a_w, op_ch.a_x, op_ch.a_y, op_ch.a_z,
                                  op_ch.b_w, op_ch.b_x, op_ch.b_y, op_ch.b_z});
    if (!rst && op_ch.valid && !op_ch.ready)
      stalled_in++;
  end

  // watch accepted result words
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(quat_res_t'{res_ch.r_w, res_ch.r_x, res_ch.r_y, res_ch.r_z,
                                  res_ch.overflow});
  end

  // result side: stall patterns that change now and then, plus one long hold
  initial begin
    int unsigned style, left, hold;
    style = 0;
    left = 0;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
        held_cycles++;
      end else begin
        if (left == 0) begin
          style = $urandom_range(0, 3);
          left = $urandom_range(8, 64);
        end
        left--;
        case (style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= left[0];
        endcase
      end
    end
  end

  function automatic quat_op_t mk(logic m, word_t aw, word_t ax, word_t ay, word_t az,
                                  word_t bw, word_t bx, word_t by, word_t bz);
    quat_op_t it;
    it = '{m, aw, ax, ay, az, bw, bx, by, bz};
    return it;
  endfunction

  // word of a given flavor: full range, edge values, unit-scale or mid-scale
  function automatic word_t rand_word(int unsigned flavor);
    int v;
    case (flavor)
      0: return word_t'($urandom);
      1: begin
        case ($urandom_range(0, 6))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return word_t'(0);
          3: return word_t'(1);
          4: return word_t'(-1);
          5: return FIX_ONE;
          default: return -FIX_ONE;
        endcase
      end
      2: v = $urandom_range(0, 32768);
      default: v = $urandom_range(0, 1 << 24);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return word_t'(v);
  endfunction

  function automatic quat_op_t rand_op();
    quat_op_t it;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    it.mode = 1'($urandom_range(0, 1));
    if (pick < 6) begin
      // rotation-like: a near unit scale, b mid scale
      it = mk(it.mode, rand_word(2), rand_word(2), rand_word(2), rand_word(2),
              rand_word(3), rand_word(3), rand_word(3), rand_word(3));
    end else if (pick < 8) begin
      it = mk(it.mode, rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
              rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
              rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
              rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)));
    end else begin
      it = mk(it.mode, rand_word(0), rand_word(0), rand_word(0), rand_word(0),
              rand_word(0), rand_word(0), rand_word(0), rand_word(0));
    end
    return it;
  endfunction

  // offer one word and hold it until taken
  task automatic send_op(input quat_op_t it);
    op_ch.valid <= 1'b1;
    op_ch.mode  <= it.mode;
    op_ch.a_w   <= it.a_w;
    op_ch.a_x   <= it.a_x;
    op_ch.a_y   <= it.a_y;
    op_ch.a_z   <= it.a_z;
    op_ch.b_w   <= it.b_w;
    op_ch.b_x   <= it.b_x;
    op_ch.b_y   <= it.b_y;
    op_ch.b_z   <= it.b_z;
    do @(posedge clk); while (op_ch.ready !== 1'b1);
  endtask

  // sender gap with junk on the payload
  task automatic idle_for(input int unsigned n);
    op_ch.valid <= 1'b0;
    op_ch.mode  <= 1'($urandom_range(0, 1));
    op_ch.a_w   <= word_t'($urandom);
    op_ch.b_z   <= word_t'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // sender pauses until every owed result is back
  task automatic wait_drained();
    idle_for(1);
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // random words in bursts, some runs without any gap
  task automatic send_random(input int unsigned n);
    int unsigned burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        send_op(rand_op());
        burst--;
        n--;
      end
      if ($urandom_range(0, 4) != 0) idle_for($urandom_range(1, 9));
    end
  endtask

  task automatic send_directed();
    word_t one, half;
    one = FIX_ONE;
    half = word_t'(32768);
    // zeros, identities, basis products
    send_op(mk(MODE_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(mk(MODE_PRODUCT, one, 0, 0, 0, one, 0, 0, 0));
    send_op(mk(MODE_PRODUCT, 0, one, 0, 0, 0, 0, one, 0));
    send_op(mk(MODE_PRODUCT, one, 2 * one, 3 * one, 4 * one,
               5 * one, 6 * one, 7 * one, 8 * one));
    // saturation on every part, then on the scalar only, then on one vector part only
    send_op(mk(MODE_PRODUCT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
               WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send_op(mk(MODE_PRODUCT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
               WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send_op(mk(MODE_PRODUCT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
               WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send_op(mk(MODE_PRODUCT, WORD_MAX, 0, 0, 0, 2 * one, 0, 0, 0));
    send_op(mk(MODE_PRODUCT, WORD_MIN, WORD_MAX, -1, 1, WORD_MAX, WORD_MIN, 1, -1));
    // rounding ties in both signs and just below a tie
    send_op(mk(MODE_PRODUCT, 1, 0, 0, 0, half, 0, 0, 0));
    send_op(mk(MODE_PRODUCT, -1, 0, 0, 0, half, 0, 0, 0));
    send_op(mk(MODE_PRODUCT, 1, 0, 0, 0, half - 1, 0, 0, 0));
    send_op(mk(MODE_PRODUCT, half, -half, 16384, 1, -1, 1, -1, 1));
    // rotation: identity with b_w ignored, quarter turn, half turn, identity on extreme words, zero rotor
    send_op(mk(MODE_ROTATE, one, 0, 0, 0, 12345, one, 2 * one, 3 * one));
    send_op(mk(MODE_ROTATE, 46341, 0, 0, 46341, 0, one, 0, 0));
    send_op(mk(MODE_ROTATE, 0, one, 0, 0, 0, 0, one, 0));
    send_op(mk(MODE_ROTATE, one, 0, 0, 0, WORD_MIN, WORD_MAX, WORD_MIN, 0));
    send_op(mk(MODE_ROTATE, 0, 0, 0, 0, WORD_MIN, one, one, one));
    // conjugate of the most negative word stays exact
    send_op(mk(MODE_ROTATE, 0, WORD_MIN, 0, 0, 0, 1, 2, 3));
    // first pass saturates; then only the second pass saturates; then the first pass again
    send_op(mk(MODE_ROTATE, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
               WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send_op(mk(MODE_ROTATE, 256 * one, 0, 0, 0, 0, one, 0, 0));
    send_op(mk(MODE_ROTATE, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
               WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
  endtask

  // main sequence
  initial begin
    int unsigned i;
    op_ch.valid <= 1'b0;
    op_ch.mode  <= MODE_PRODUCT;
    op_ch.a_w   <= '0;
    op_ch.a_x   <= '0;
    op_ch.a_y   <= '0;
    op_ch.a_z   <= '0;
    op_ch.b_w   <= '0;
    op_ch.b_x   <= '0;
    op_ch.b_y   <= '0;
    op_ch.b_z   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_directed();
    wait_drained();

    send_random(500);
    wait_drained();

    // long result hold while words keep coming, so the pipe fills
    hold_request = 1'b1;
    for (i = 0; i < 80; i++) send_op(rand_op());
    idle_for(1);

    send_random(1000);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d products and %0d rotations, %0d of them saturating",
             sb.n_products, sb.n_rotations, sb.n_saturated);
    $display("checked %0d results; input back-pressure %0d cycles, long hold %0d cycles",
             sb.n_checked, stalled_in, held_cycles);
    if (sb.n_errors == 0 && sb.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors", sb.n_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
